// File: src/assert_macros.svh
// Assertion macros shared by the divider RTL.
// Depends on nothing; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted (active low)
`define FDIV_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same, checked during reset as well
`define FDIV_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/fdiv_pkg.sv
// Types, constants and the step function of the Q31 by Q15 divider.
// No dependencies; used by every divider module.
package fdiv_pkg;

	localparam int unsigned FDIV_STEPS           = 15;
	localparam int unsigned FDIV_STEPS_PER_STAGE = 3;
	localparam int unsigned FDIV_NUM_STAGES      = FDIV_STEPS / FDIV_STEPS_PER_STAGE;

	localparam logic [15:0] FDIV_Q_NEG_LIMIT = 16'h8000;
	localparam logic [15:0] FDIV_Q_POS_LIMIT = 16'h7fff;

	typedef struct packed {
		logic [31:0] rem;      // partial remainder word
		logic [15:0] dsr;      // divisor, upper half of the divisor word
		logic        add;      // next operation: add when set
		logic        dsr_zero; // divisor was zero
		logic        dvd_neg;  // dividend was negative
	} fdiv_data_t;

	typedef struct packed {
		logic [31:0] rem;
		logic        add;
	} fdiv_step_t;

	// one add/subtract-and-shift step
	function automatic fdiv_step_t fdiv_step(input logic [31:0] rem, input logic [15:0] dsr,
		input logic add);
		logic [31:0] dsr_w;
		logic [31:0] sum;
		fdiv_step_t  res;
		dsr_w   = {dsr, 16'h0000};
		sum     = add ? (rem + dsr_w) : (rem - dsr_w);
		res.add = sum[31] ^ dsr[15];
		res.rem = {sum[30:0], ~res.add};
		return res;
	endfunction

endpackage

// File: src/fdiv_entry.sv
// Input register of the divider: sign compare and first shift.
// Depends on fdiv_pkg.
module fdiv_entry (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  dividend,
	input  logic signed [15:0]  divisor,
	output logic                out_valid,
	input  logic                out_stall,
	output fdiv_pkg::fdiv_data_t out_data
);

	logic                 valid_s1;
	fdiv_pkg::fdiv_data_t data_s1;
	fdiv_pkg::fdiv_data_t data_d;
	logic                 load;

	always_comb begin
		data_d.add      = dividend[31] ^ divisor[15];
		data_d.rem      = {dividend[30:0], data_d.add};
		data_d.dsr      = divisor;
		data_d.dsr_zero = (divisor == 16'sd0);
		data_d.dvd_neg  = dividend[31];
	end

	assign load     = !valid_s1 || !out_stall;
	assign in_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			data_s1 <= data_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// File: src/fdiv_stage.sv
// One pipeline stage of the divider: a group of add/subtract-and-shift steps.
// Depends on fdiv_pkg.
module fdiv_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  fdiv_pkg::fdiv_data_t in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output fdiv_pkg::fdiv_data_t out_data
);

	logic                 valid_q;
	fdiv_pkg::fdiv_data_t data_q;
	fdiv_pkg::fdiv_data_t data_d;
	logic                 load;

	always_comb begin
		fdiv_pkg::fdiv_step_t st;
		data_d = in_data;
		for (int unsigned i = 0; i < fdiv_pkg::FDIV_STEPS_PER_STAGE; i++) begin
			st         = fdiv_pkg::fdiv_step(data_d.rem, data_d.dsr, data_d.add);
			data_d.rem = st.rem;
			data_d.add = st.add;
		end
	end

	assign load     = !valid_q || !out_stall;
	assign in_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			data_q <= data_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// File: src/q31_by_q15_fraction_divider.sv
// Q31 by Q15 fractional divider, non-restoring, one request per cycle while not stalled.
// Input register, then 5 stages of 3 add/subtract steps each.
// Throughput 1 request per cycle while out_stall is low; the 32-bit add chain of 3 steps sets the stage depth.
// Each stage holds its data under out stall and fills bubbles behind it.
// arst_n clears all valid bits asynchronously; payload registers are not reset.
// Depends on fdiv_pkg, fdiv_entry, fdiv_stage and assert_macros.svh.
`include "assert_macros.svh"

module q31_by_q15_fraction_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] dividend,
	input  logic signed [15:0] divisor,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] quotient
);

	localparam int unsigned NS = fdiv_pkg::FDIV_NUM_STAGES;

	logic                 vld  [0:NS];
	logic                 stl  [0:NS];
	fdiv_pkg::fdiv_data_t data [0:NS];

	fdiv_entry u_entry (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.dividend  (dividend),
		.divisor   (divisor),
		.out_valid (vld[0]),
		.out_stall (stl[0]),
		.out_data  (data[0])
	);

	for (genvar k = 0; k < NS; k++) begin : g_stage
		fdiv_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[k]),
			.in_stall  (stl[k]),
			.in_data   (data[k]),
			.out_valid (vld[k+1]),
			.out_stall (stl[k+1]),
			.out_data  (data[k+1])
		);
	end

	assign stl[NS]   = out_stall;
	assign out_valid = vld[NS];

	always_comb begin
		if (data[NS].dsr_zero) begin
			quotient = data[NS].dvd_neg ? fdiv_pkg::FDIV_Q_NEG_LIMIT
				: fdiv_pkg::FDIV_Q_POS_LIMIT;
		end else begin
			quotient = data[NS].rem[15:0];
		end
	end

	// input backpressure only when the output is stalled with every stage full
	`FDIV_ASSERT_ALWAYS(a_stall_src, clk, !in_stall || (out_valid && out_stall && vld[0]), "in_stall without full stalled pipe")
	`FDIV_ASSERT(a_free_flow, clk, arst_n, !out_stall |-> !in_stall, "in_stall while output drains")

	for (genvar k = 0; k < NS; k++) begin : g_chk
		// a stalled stage keeps its request
		`FDIV_ASSERT(a_hold, clk, arst_n, (vld[k] && stl[k]) |=> vld[k], "stalled stage lost its request")
	end

endmodule
